@@ rtl/core/rtlpm_pkg.sv @@
// Shared definitions for the longest prefix match routing table.
// Holds table sizing, command and status codes, the controller-to-datapath
// command struct and the prefix mask helper. Depends on nothing.
package rtlpm_pkg;

    // Table sizing.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Field widths of one table entry.
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int PORT_W   = 8;
    localparam int METRIC_W = 5;
    localparam int ENTRY_W  = ADDR_W + LEN_W + PORT_W + ADDR_W + METRIC_W;

    // Longest legal prefix length.
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    // Command codes.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_cmd;  // capture a new transaction, clear accumulators
        logic             rd_en;     // read one table slot this cycle
        logic [IDX_W-1:0] rd_addr;   // slot being read
        logic             commit;    // update the table and load the result
    } rtlpm_cmd_t;

    // Network mask for a prefix length; lengths of 32 and above give all ones.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        if (len == '0) begin
            mask = '0;
        end else if (len >= MAX_LEN) begin
            mask = '1;
        end else begin
            mask = ~({ADDR_W{1'b1}} >> len);
        end
        return mask;
    endfunction

endpackage

@@ rtl/core/route_table_longest_prefix_match.sv @@
// IPv4 longest prefix match routing table, top level; joins rtlpm_ctrl and rtlpm_dp.
// Every transaction scans all TABLE_DEPTH slots, one memory read per cycle, then
// passes through a drain step and a finish step that loads the result register;
// a new transaction is taken only after the finish step of the one before.
// A result waiting at the output does not block acceptance of the next transaction.
// Synchronous active-low reset clears all valid bits at once; no clearing pass.
module route_table_longest_prefix_match (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_cmd,
    input  logic [rtlpm_pkg::ADDR_W-1:0]   s_address,
    input  logic [rtlpm_pkg::LEN_W-1:0]    s_prefix_len,
    input  logic [rtlpm_pkg::PORT_W-1:0]   s_out_port,
    input  logic [rtlpm_pkg::ADDR_W-1:0]   s_next_hop,
    input  logic [rtlpm_pkg::METRIC_W-1:0] s_route_metric,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [rtlpm_pkg::ADDR_W-1:0]   m_hit_next_hop,
    output logic [rtlpm_pkg::PORT_W-1:0]   m_hit_port,
    output logic [rtlpm_pkg::METRIC_W-1:0] m_hit_metric
);

    rtlpm_pkg::rtlpm_cmd_t dp_cmd;

    // Handshake and scan sequencing.
    rtlpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (dp_cmd)
    );

    // Table storage and match logic.
    rtlpm_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (dp_cmd),
        .s_cmd          (s_cmd),
        .s_address      (s_address),
        .s_prefix_len   (s_prefix_len),
        .s_out_port     (s_out_port),
        .s_next_hop     (s_next_hop),
        .s_route_metric (s_route_metric),
        .m_status       (m_status),
        .m_hit_next_hop (m_hit_next_hop),
        .m_hit_port     (m_hit_port),
        .m_hit_metric   (m_hit_metric)
    );

endmodule

@@ rtl/core/rtlpm_ctrl.sv @@
// Controller state machine for the routing table: handshakes and slot scan.
// Drives the datapath through rtlpm_pkg::rtlpm_cmd_t; uses rtlpm_pkg.
module rtlpm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output rtlpm_pkg::rtlpm_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [rtlpm_pkg::IDX_W-1:0] LAST_IDX =
        rtlpm_pkg::IDX_W'(rtlpm_pkg::TABLE_DEPTH - 1);

    logic [1:0]                  state_reg, state_next;
    logic [rtlpm_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Next state, scan counter and command decode.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd.load_cmd = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_addr  = cnt_reg;
        cmd.commit   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_cmd = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // The last slot read is evaluated in this cycle.
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A result is only committed when the output register is free.
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> out_free)
        else $error("result committed while output register was occupied");

    // An accepted transaction starts a scan at slot zero.
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("scan did not start at slot zero");

    // The drain cycle is always followed by the finish step.
    a_drain_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |=> (state_reg == ST_FINISH))
        else $error("drain cycle not followed by finish");

    // A commit always presents a result on the next cycle.
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("commit did not raise the result valid");

endmodule

@@ rtl/core/rtlpm_dp.sv @@
// Datapath for the routing table: entry memory, valid bits, match logic,
// accumulators and the result register. Driven by rtlpm_ctrl; uses rtlpm_pkg.
module rtlpm_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rtlpm_pkg::rtlpm_cmd_t               cmd,
    input  logic [1:0]                          s_cmd,
    input  logic [rtlpm_pkg::ADDR_W-1:0]        s_address,
    input  logic [rtlpm_pkg::LEN_W-1:0]         s_prefix_len,
    input  logic [rtlpm_pkg::PORT_W-1:0]        s_out_port,
    input  logic [rtlpm_pkg::ADDR_W-1:0]        s_next_hop,
    input  logic [rtlpm_pkg::METRIC_W-1:0]      s_route_metric,
    output logic [1:0]                          m_status,
    output logic [rtlpm_pkg::ADDR_W-1:0]        m_hit_next_hop,
    output logic [rtlpm_pkg::PORT_W-1:0]        m_hit_port,
    output logic [rtlpm_pkg::METRIC_W-1:0]      m_hit_metric
);

    localparam int AW = rtlpm_pkg::ADDR_W;
    localparam int LW = rtlpm_pkg::LEN_W;
    localparam int PW = rtlpm_pkg::PORT_W;
    localparam int MW = rtlpm_pkg::METRIC_W;
    localparam int IW = rtlpm_pkg::IDX_W;

    // Entry storage and valid bits.
    logic [rtlpm_pkg::ENTRY_W-1:0]     mem [rtlpm_pkg::TABLE_DEPTH];
    logic [rtlpm_pkg::TABLE_DEPTH-1:0] valid_reg;

    // Captured transaction.
    logic [1:0]    cmd_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] pfx_reg;
    logic [LW-1:0] len_reg;
    logic [PW-1:0] port_reg;
    logic [AW-1:0] nh_reg;
    logic [MW-1:0] met_reg;

    // Registered read of one slot.
    logic [rtlpm_pkg::ENTRY_W-1:0] rd_data_reg;
    logic                          rd_slot_valid_reg;
    logic                          rd_vld_reg;
    logic [IW-1:0]                 rd_idx_reg;

    // Accumulators.
    logic          k_found_reg;
    logic [IW-1:0] k_idx_reg;
    logic          f_found_reg;
    logic [IW-1:0] f_idx_reg;
    logic          q_found_reg;
    logic [LW-1:0] q_len_reg;
    logic [AW-1:0] q_nh_reg;
    logic [PW-1:0] q_port_reg;
    logic [MW-1:0] q_met_reg;

    // Result register.
    logic [1:0]    status_reg;
    logic [AW-1:0] hit_nh_reg;
    logic [PW-1:0] hit_port_reg;
    logic [MW-1:0] hit_met_reg;

    logic [LW-1:0] len_sat;
    logic [AW-1:0] e_pfx;
    logic [LW-1:0] e_len;
    logic [PW-1:0] e_port;
    logic [AW-1:0] e_nh;
    logic [MW-1:0] e_met;
    logic          key_hit;
    logic          route_hit;
    logic          better;

    logic [1:0]    res_status;
    logic [AW-1:0] res_nh;
    logic [PW-1:0] res_port;
    logic [MW-1:0] res_met;
    logic          do_write;
    logic          do_clear;
    logic [IW-1:0] wr_idx;

    // Lengths above 32 saturate.
    assign len_sat = (s_prefix_len > rtlpm_pkg::MAX_LEN) ? rtlpm_pkg::MAX_LEN : s_prefix_len;

    // Capture the transaction, with host bits cleared from the prefix.
    always_ff @(posedge aclk) begin
        if (cmd.load_cmd) begin
            cmd_reg  <= s_cmd;
            addr_reg <= s_address;
            pfx_reg  <= s_address & rtlpm_pkg::len_mask(len_sat);
            len_reg  <= len_sat;
            port_reg <= s_out_port;
            nh_reg   <= s_next_hop;
            met_reg  <= s_route_metric;
        end
    end

    // Unpack the slot read in the previous cycle.
    assign {e_pfx, e_len, e_port, e_nh, e_met} = rd_data_reg;

    // Match terms for the slot under evaluation.
    assign key_hit   = rd_vld_reg && rd_slot_valid_reg
                       && (e_pfx == pfx_reg) && (e_len == len_reg);
    assign route_hit = rd_vld_reg && rd_slot_valid_reg
                       && ((addr_reg & rtlpm_pkg::len_mask(e_len)) == e_pfx);
    assign better    = route_hit && (!q_found_reg || (e_len > q_len_reg));

    // Result and table update for the finished scan.
    always_comb begin
        res_status = rtlpm_pkg::ST_MISS;
        res_nh     = '0;
        res_port   = '0;
        res_met    = '0;
        do_write   = 1'b0;
        do_clear   = 1'b0;
        wr_idx     = k_found_reg ? k_idx_reg : f_idx_reg;
        case (cmd_reg)
            rtlpm_pkg::CMD_INSERT: begin
                if (k_found_reg || f_found_reg) begin
                    do_write   = 1'b1;
                    res_status = rtlpm_pkg::ST_OK;
                end else begin
                    res_status = rtlpm_pkg::ST_FULL;
                end
            end
            rtlpm_pkg::CMD_DELETE: begin
                if (k_found_reg) begin
                    do_clear   = 1'b1;
                    res_status = rtlpm_pkg::ST_OK;
                end
            end
            rtlpm_pkg::CMD_QUERY: begin
                if (q_found_reg) begin
                    res_status = rtlpm_pkg::ST_OK;
                    res_nh     = q_nh_reg;
                    res_port   = q_port_reg;
                    res_met    = q_met_reg;
                end
            end
            default: begin
                res_status = rtlpm_pkg::ST_MISS;
            end
        endcase
    end

    // Entry memory: registered read during the scan, write on commit.
    always_ff @(posedge aclk) begin
        if (cmd.commit && do_write) begin
            mem[wr_idx] <= {pfx_reg, len_reg, port_reg, nh_reg, met_reg};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    // Valid bits, cleared by reset; on commit, set by an insert and cleared by a delete.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.commit) begin
            if (do_write) begin
                valid_reg[wr_idx] <= 1'b1;
            end else if (do_clear) begin
                valid_reg[k_idx_reg] <= 1'b0;
            end
        end
    end

    // Read tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
        end
        rd_idx_reg        <= cmd.rd_addr;
        rd_slot_valid_reg <= valid_reg[cmd.rd_addr];
    end

    // Accumulators: first key match, first free slot, longest matching route.
    always_ff @(posedge aclk) begin
        if (cmd.load_cmd) begin
            k_found_reg <= 1'b0;
            f_found_reg <= 1'b0;
            q_found_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (key_hit && !k_found_reg) begin
                k_found_reg <= 1'b1;
                k_idx_reg   <= rd_idx_reg;
            end
            if (!rd_slot_valid_reg && !f_found_reg) begin
                f_found_reg <= 1'b1;
                f_idx_reg   <= rd_idx_reg;
            end
            if (better) begin
                q_found_reg <= 1'b1;
                q_len_reg   <= e_len;
                q_nh_reg    <= e_nh;
                q_port_reg  <= e_port;
                q_met_reg   <= e_met;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg   <= res_status;
            hit_nh_reg   <= res_nh;
            hit_port_reg <= res_port;
            hit_met_reg  <= res_met;
        end
    end

    assign m_status       = status_reg;
    assign m_hit_next_hop = hit_nh_reg;
    assign m_hit_port     = hit_port_reg;
    assign m_hit_metric   = hit_met_reg;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for route_table_longest_prefix_match: directed and random
// insert, delete and query transactions, checked against a table predictor kept here.
// Depends on rtlpm_pkg and the RTL top level only.
module tb;

    // Sizes and codes taken from the package.
    localparam int TABLE_DEPTH = rtlpm_pkg::TABLE_DEPTH;
    localparam int ADDR_W      = rtlpm_pkg::ADDR_W;
    localparam int LEN_W       = rtlpm_pkg::LEN_W;
    localparam int PORT_W      = rtlpm_pkg::PORT_W;
    localparam int METRIC_W    = rtlpm_pkg::METRIC_W;

    localparam logic [1:0] CMD_INSERT = rtlpm_pkg::CMD_INSERT;
    localparam logic [1:0] CMD_DELETE = rtlpm_pkg::CMD_DELETE;
    localparam logic [1:0] CMD_QUERY  = rtlpm_pkg::CMD_QUERY;
    localparam logic [1:0] ST_OK      = rtlpm_pkg::ST_OK;
    localparam logic [1:0] ST_MISS    = rtlpm_pkg::ST_MISS;
    localparam logic [1:0] ST_FULL    = rtlpm_pkg::ST_FULL;

    // The command code that the block leaves unused.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned ROUTE_CMD_COUNT = 1250;
    localparam int unsigned SCAN_CYCLES     = TABLE_DEPTH + 3;
    localparam int unsigned HOLD_AFTER      = 300;
    localparam int unsigned LONG_HOLD       = 20 * SCAN_CYCLES;
    localparam int unsigned CYCLE_LIMIT     = 2000000;
    localparam int unsigned MAX_REPORTS     = 100;

    typedef enum {PH_FILL, PH_MIX, PH_DRAIN} load_phase_t;

    typedef struct {
        logic [1:0]          cmd;
        logic [ADDR_W-1:0]   address;
        logic [LEN_W-1:0]    prefix_len;
        logic [PORT_W-1:0]   port;
        logic [ADDR_W-1:0]   next_hop;
        logic [METRIC_W-1:0] metric;
        bit                  drain_first;
    } route_cmd_t;

    typedef struct {
        logic [1:0]          status;
        logic [ADDR_W-1:0]   next_hop;
        logic [PORT_W-1:0]   port;
        logic [METRIC_W-1:0] metric;
    } route_result_t;

    typedef struct {
        logic [ADDR_W-1:0] prefix;
        int unsigned       len;
    } route_key_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [1:0]          s_cmd          = '0;
    logic [ADDR_W-1:0]   s_address      = '0;
    logic [LEN_W-1:0]    s_prefix_len   = '0;
    logic [PORT_W-1:0]   s_out_port     = '0;
    logic [ADDR_W-1:0]   s_next_hop     = '0;
    logic [METRIC_W-1:0] s_route_metric = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [1:0]          m_status;
    logic [ADDR_W-1:0]   m_hit_next_hop;
    logic [PORT_W-1:0]   m_hit_port;
    logic [METRIC_W-1:0] m_hit_metric;

    // Predicted routing table.
    bit                  table_valid    [TABLE_DEPTH];
    logic [ADDR_W-1:0]   table_prefix   [TABLE_DEPTH];
    int unsigned         table_len      [TABLE_DEPTH];
    logic [PORT_W-1:0]   table_port     [TABLE_DEPTH];
    logic [ADDR_W-1:0]   table_next_hop [TABLE_DEPTH];
    logic [METRIC_W-1:0] table_metric   [TABLE_DEPTH];

    route_cmd_t    pending_commands [$];
    route_result_t expected_results [$];
    // Keys the generated sequence leaves installed, used to aim deletes and queries.
    route_key_t    installed_keys   [$];

    route_cmd_t  offered_cmd;
    int unsigned commands_accepted = 0;
    int unsigned results_checked   = 0;
    int unsigned error_count       = 0;
    int unsigned cycle_count       = 0;
    int unsigned send_gap          = 0;
    int unsigned stall_left        = 0;
    bit          long_hold_done    = 1'b0;

    // Top len bits set: 2^32 shifted right by len, minus one, gives the host bits.
    function automatic logic [ADDR_W-1:0] route_mask(input int unsigned bits);
        logic [ADDR_W:0] span;
        span = {1'b1, {ADDR_W{1'b0}}} >> bits;
        return ADDR_W'(~(span - 1'b1));
    endfunction

    function automatic int unsigned clamp_len(input logic [LEN_W-1:0] raw);
        return (raw > ADDR_W) ? ADDR_W : raw;
    endfunction

    function automatic int find_route(input logic [ADDR_W-1:0] pfx, input int unsigned len);
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (table_valid[i] && table_prefix[i] == pfx && table_len[i] == len) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one transaction to the predicted table and returns its result.
    function automatic route_result_t apply_route_command(input route_cmd_t c);
        route_result_t     res;
        int unsigned       len;
        logic [ADDR_W-1:0] pfx;
        int                slot;
        int                i;
        res.status   = ST_MISS;
        res.next_hop = '0;
        res.port     = '0;
        res.metric   = '0;
        len  = clamp_len(c.prefix_len);
        pfx  = c.address & route_mask(len);
        slot = -1;
        case (c.cmd)
            CMD_INSERT: begin
                // Replace a matching key, else take the lowest free slot.
                slot = find_route(pfx, len);
                for (i = 0; i < TABLE_DEPTH && slot < 0; i++) begin
                    if (!table_valid[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    table_valid[slot]    = 1'b1;
                    table_prefix[slot]   = pfx;
                    table_len[slot]      = len;
                    table_port[slot]     = c.port;
                    table_next_hop[slot] = c.next_hop;
                    table_metric[slot]   = c.metric;
                    res.status           = ST_OK;
                end
            end
            CMD_DELETE: begin
                slot = find_route(pfx, len);
                if (slot >= 0) begin
                    table_valid[slot] = 1'b0;
                    res.status        = ST_OK;
                end
            end
            CMD_QUERY: begin
                // Longest match wins; on equal lengths the lowest slot stays.
                for (i = 0; i < TABLE_DEPTH; i++) begin
                    if (table_valid[i] && (c.address & route_mask(table_len[i])) == table_prefix[i]
                            && (slot < 0 || table_len[i] > table_len[slot])) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    res.status   = ST_OK;
                    res.next_hop = table_next_hop[slot];
                    res.port     = table_port[slot];
                    res.metric   = table_metric[slot];
                end
            end
            default: begin
                // The unused command changes nothing and answers a miss.
            end
        endcase
        return res;
    endfunction

    function automatic int key_index(input logic [ADDR_W-1:0] pfx, input int unsigned len);
        foreach (installed_keys[i]) begin
            if (installed_keys[i].prefix == pfx && installed_keys[i].len == len) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Queues one transaction and tracks which keys it leaves installed.
    function automatic void queue_command(input logic [1:0] cmd,
                                          input logic [ADDR_W-1:0] address,
                                          input logic [LEN_W-1:0] prefix_len,
                                          input logic [PORT_W-1:0] port,
                                          input logic [ADDR_W-1:0] next_hop,
                                          input logic [METRIC_W-1:0] metric,
                                          input bit drain_first);
        route_cmd_t c;
        route_key_t k;
        int         idx;
        c = '{cmd, address, prefix_len, port, next_hop, metric, drain_first};
        k.len    = clamp_len(prefix_len);
        k.prefix = address & route_mask(k.len);
        idx      = key_index(k.prefix, k.len);
        if (cmd == CMD_INSERT && idx < 0 && installed_keys.size() < TABLE_DEPTH) begin
            installed_keys = {installed_keys, k};
        end else if (cmd == CMD_DELETE && idx >= 0) begin
            installed_keys.delete(idx);
        end
        pending_commands = {pending_commands, c};
    endfunction

    function automatic route_key_t pick_installed();
        return installed_keys[$urandom_range(0, installed_keys.size() - 1)];
    endfunction

    // Fills the host bits of a key with random values.
    function automatic logic [ADDR_W-1:0] host_fill(input route_key_t k);
        return k.prefix | ($urandom & ~route_mask(k.len));
    endfunction

    // A /32 is sometimes given as a longer length, which saturates.
    function automatic logic [LEN_W-1:0] encode_len(input int unsigned len);
        if (len == ADDR_W && $urandom_range(0, 2) == 0) begin
            return LEN_W'($urandom_range(ADDR_W + 1, 63));
        end
        return LEN_W'(len);
    endfunction

    // New keys often sit inside or around installed ones so that routes nest.
    function automatic route_key_t fresh_key();
        route_key_t        k;
        logic [ADDR_W-1:0] base;
        int unsigned       r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            k.len = 0;
        end else if (r < 20) begin
            k.len = 8;
        end else if (r < 35) begin
            k.len = 16;
        end else if (r < 50) begin
            k.len = 24;
        end else if (r < 65) begin
            k.len = 32;
        end else begin
            k.len = $urandom_range(1, 31);
        end
        if (installed_keys.size() != 0 && $urandom_range(0, 99) < 60) begin
            base = host_fill(pick_installed());
        end else begin
            base = $urandom;
        end
        k.prefix = base & route_mask(k.len);
        return k;
    endfunction

    function automatic logic [1:0] pick_command(input load_phase_t phase, input int unsigned r);
        case (phase)
            PH_FILL: begin
                return (r < 70) ? CMD_INSERT : (r < 92) ? CMD_QUERY
                                             : (r < 98) ? CMD_DELETE : CMD_UNUSED;
            end
            PH_MIX: begin
                return (r < 35) ? CMD_INSERT : (r < 60) ? CMD_DELETE
                                             : (r < 97) ? CMD_QUERY : CMD_UNUSED;
            end
            default: begin
                return (r < 8) ? CMD_INSERT : (r < 65) ? CMD_DELETE
                                            : (r < 97) ? CMD_QUERY : CMD_UNUSED;
            end
        endcase
    endfunction

    // Idle lengths: mostly short, a few long.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 4);
        end else if (r < 95) begin
            return $urandom_range(5, 40);
        end
        return $urandom_range(41, 160);
    endfunction

    // Every fifth block of 100 transactions runs with no idling on either side.
    function automatic bit quiet_stretch();
        return (commands_accepted / 100) % 5 == 2;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR at result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_checked, what, got, want);
        end
    endtask

    route_table_longest_prefix_match uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_address      (s_address),
        .s_prefix_len   (s_prefix_len),
        .s_out_port     (s_out_port),
        .s_next_hop     (s_next_hop),
        .s_route_metric (s_route_metric),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_hit_next_hop (m_hit_next_hop),
        .m_hit_port     (m_hit_port),
        .m_hit_metric   (m_hit_metric)
    );

    // Clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Driver: offers queued transactions, with random gaps and pauses for draining.
    always @(posedge aclk) begin
        route_cmd_t c;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            // An accepted transaction updates the predicted table at once.
            if (s_valid && s_ready) begin
                expected_results = {expected_results, apply_route_command(offered_cmd)};
                commands_accepted <= commands_accepted + 1;
            end
            // Offer the next transaction once the current one is gone.
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_commands.size() == 0 || (pending_commands[0].drain_first
                             && expected_results.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    c = pending_commands.pop_front();
                    s_valid        <= 1'b1;
                    s_cmd          <= c.cmd;
                    s_address      <= c.address;
                    s_prefix_len   <= c.prefix_len;
                    s_out_port     <= c.port;
                    s_next_hop     <= c.next_hop;
                    s_route_metric <= c.metric;
                    offered_cmd    <= c;
                    if (quiet_stretch() || $urandom_range(0, 99) < 45) begin
                        send_gap <= 0;
                    end else begin
                        send_gap <= idle_length();
                    end
                end
            end
        end
    end

    // Monitor: checks each result transaction and stalls the output at random.
    always @(posedge aclk) begin
        route_result_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no transaction outstanding",
                                    ADDR_W'(m_status), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status) begin
                        report_mismatch("status", ADDR_W'(m_status), ADDR_W'(want.status));
                    end
                    if (m_hit_next_hop !== want.next_hop) begin
                        report_mismatch("hit_next_hop", m_hit_next_hop, want.next_hop);
                    end
                    if (m_hit_port !== want.port) begin
                        report_mismatch("hit_port", ADDR_W'(m_hit_port), ADDR_W'(want.port));
                    end
                    if (m_hit_metric !== want.metric) begin
                        report_mismatch("hit_metric", ADDR_W'(m_hit_metric),
                                        ADDR_W'(want.metric));
                    end
                end
                results_checked++;
            end
            // One long hold lets the block fill up and back-pressure its input.
            if (!long_hold_done && commands_accepted >= HOLD_AFTER) begin
                long_hold_done <= 1'b1;
                stall_left     <= LONG_HOLD;
                m_ready        <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (!quiet_stretch() && $urandom_range(0, 99) < 5) begin
                stall_left <= idle_length() - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned       n;
        int unsigned       r;
        int unsigned       start;
        load_phase_t       phase;
        route_key_t        k;
        logic [ADDR_W-1:0] addr;
        bit                drain;

        // Empty table: query, delete and the unused command all miss.
        queue_command(CMD_QUERY,  32'hFFFF_FFFF, 6'd32, 8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_DELETE, 32'h0000_0000, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_UNUSED, 32'hA5A5_A5A5, 6'd63, 8'hFF, 32'hFFFF_FFFF, 5'd16, 1'b0);
        // Default route; its host bits are dropped and it matches everything.
        queue_command(CMD_INSERT, 32'hDEAD_BEEF, 6'd0,  8'hFF, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_QUERY,  32'h0000_0000, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        // Nested routes, one off a byte boundary, and a host route given as /40.
        queue_command(CMD_INSERT, 32'h0A12_3456, 6'd8,  8'h01, 32'hC0A8_0001, 5'd16, 1'b0);
        queue_command(CMD_INSERT, 32'h0A13_FFFF, 6'd15, 8'h02, 32'hFFFF_FFFF, 5'd1, 1'b0);
        queue_command(CMD_INSERT, 32'h0A12_3456, 6'd40, 8'h03, 32'h0102_0304, 5'd5, 1'b0);
        queue_command(CMD_QUERY,  32'h0A12_3456, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_QUERY,  32'h0A12_3457, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_QUERY,  32'h0A80_0000, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_QUERY,  32'h0B00_0000, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        // Replace the /8 in place.
        queue_command(CMD_INSERT, 32'h0A00_0000, 6'd8,  8'hAA, 32'h5555_5555, 5'd8, 1'b0);
        queue_command(CMD_QUERY,  32'h0AFF_FFFF, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        // Deletes ignore host bits; a repeated delete misses; /63 saturates to /32.
        queue_command(CMD_DELETE, 32'h0A12_0001, 6'd15, 8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_DELETE, 32'h0A13_0000, 6'd15, 8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_QUERY,  32'h0A12_0000, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_DELETE, 32'h0A12_3456, 6'd63, 8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_DELETE, 32'hFFFF_FFFF, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_QUERY,  32'h0100_0000, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        // All-ones host route and a near miss next to it.
        queue_command(CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 8'h80, 32'h8000_0001, 5'd16, 1'b0);
        queue_command(CMD_QUERY,  32'hFFFF_FFFF, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);
        queue_command(CMD_QUERY,  32'hFFFF_FFFE, 6'd0,  8'h00, 32'h0000_0000, 5'd0, 1'b0);

        // Random traffic in phases that fill the table past full, mix and drain it.
        start = pending_commands.size();
        for (n = start; n < ROUTE_CMD_COUNT; n++) begin
            case (((n - start) / 100) % 4)
                0, 2: phase = PH_FILL;
                1: phase = PH_MIX;
                default: phase = PH_DRAIN;
            endcase
            drain = ((n - start) % 300 == 0);
            r = $urandom_range(0, 99);
            case (pick_command(phase, r))
                CMD_INSERT: begin
                    if (installed_keys.size() != 0 && $urandom_range(0, 3) == 0) begin
                        k = pick_installed();
                    end else begin
                        k = fresh_key();
                    end
                    queue_command(CMD_INSERT, host_fill(k), encode_len(k.len),
                                  PORT_W'($urandom),
                                  ($urandom_range(0, 9) == 0) ? '0 : $urandom,
                                  METRIC_W'($urandom_range(0, 16)), drain);
                end
                CMD_DELETE: begin
                    if (installed_keys.size() != 0 && $urandom_range(0, 99) < 85) begin
                        k = pick_installed();
                    end else begin
                        k = fresh_key();
                    end
                    queue_command(CMD_DELETE, host_fill(k), encode_len(k.len),
                                  PORT_W'($urandom), $urandom,
                                  METRIC_W'($urandom_range(0, 16)), drain);
                end
                CMD_QUERY: begin
                    r = $urandom_range(0, 99);
                    if (installed_keys.size() != 0 && r < 70) begin
                        addr = host_fill(pick_installed());
                    end else if (installed_keys.size() != 0 && r < 85) begin
                        addr = host_fill(pick_installed()) ^ (32'h1 << $urandom_range(0, 31));
                    end else begin
                        addr = $urandom;
                    end
                    queue_command(CMD_QUERY, addr, LEN_W'($urandom_range(0, 63)),
                                  PORT_W'($urandom), $urandom,
                                  METRIC_W'($urandom_range(0, 16)), drain);
                end
                default: begin
                    queue_command(CMD_UNUSED, $urandom, LEN_W'($urandom_range(0, 63)),
                                  PORT_W'($urandom), $urandom,
                                  METRIC_W'($urandom_range(0, 16)), drain);
                end
            endcase
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every transaction to be taken, then for every result.
        while (pending_commands.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * SCAN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
